FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);

`endif

FILE: sv/smstep_pkg.sv
`timescale 1ns / 1ps

package smstep_pkg;

    // parameter defaults
    localparam int FRAME_US_DEF    = 20000;
    localparam int DUTY_BITS_DEF   = 10;
    localparam int ANGLE_LIMIT_DEF = 511;

    // field and port widths
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 2;
    localparam int ANGLE_FW   = 9;
    localparam int DUTY_FW    = 10;
    localparam int US_W       = 15;
    localparam int STEP_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int DIV_W      = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_POS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd3;

    // motion modes
    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ANGLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd6;

    // register reset values
    localparam logic [MODE_W-1:0]   RST_MODE        = MODE_OFF;
    localparam logic [ANGLE_FW-1:0] RST_START_ANGLE = 9'd0;
    localparam logic [ANGLE_FW-1:0] RST_STOP_ANGLE  = 9'd270;
    localparam logic [ANGLE_FW-1:0] RST_MAX_ANGLE   = 9'd270;
    localparam logic [US_W-1:0]     RST_PULSE_MIN   = 15'd500;
    localparam logic [US_W-1:0]     RST_PULSE_MAX   = 15'd2500;
    localparam logic [STEP_W-1:0]   RST_STEP_SIZE   = 10'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ANGLE_FW-1:0] new_angle;
    } t_in_word;

    typedef struct packed {
        logic [ANGLE_FW-1:0] angle;
        logic [DUTY_FW-1:0]  duty;
        logic                running;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic apply;
        logic mul1;
        logic div1_go;
        logic pulse;
        logic mul2;
        logic scale;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic max_zero;
        logic div_busy;
        logic skip_scale;
    } t_dp_status;

endpackage

FILE: sv/smstep_div.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module smstep_div #(
    parameter int QW = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [QW-1:0]                  i_dividend,
    input  logic [smstep_pkg::DIV_W-1:0]   i_rem_init,
    input  logic [smstep_pkg::DIV_W-1:0]   i_divisor,
    input  logic [$clog2(QW+1)-1:0]        i_steps,
    output logic                           o_busy,
    output logic [QW-1:0]                  o_quotient
);
    import smstep_pkg::*;

    localparam int CNT_W = $clog2(QW + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_div;
    logic [QW-1:0]       r_quo;
    logic [DIV_W+1:0]    trial;
    logic                fits;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign trial = {1'b0, r_rem, r_quo[QW-1]} - {2'b00, r_div};
    assign fits  = ~trial[DIV_W+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? trial[DIV_W-1:0] : {r_rem[DIV_W-2:0], r_quo[QW-1]};
            r_quo <= {r_quo[QW-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    `ASSERT_CLK(a_rem_below_div, i_clk, i_rst_n, r_busy |-> (r_rem < r_div), "remainder not below divisor")
    `ASSERT_CLK(a_cnt_live, i_clk, i_rst_n, r_busy |-> (r_cnt != '0), "divider busy with zero count")
    `ASSERT_CLK(a_no_restart, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")

endmodule

FILE: sv/smstep_dp.sv
`timescale 1ns / 1ps

module smstep_dp #(
    parameter int FRAME_US    = smstep_pkg::FRAME_US_DEF,
    parameter int DUTY_BITS   = smstep_pkg::DUTY_BITS_DEF,
    parameter int ANGLE_LIMIT = smstep_pkg::ANGLE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smstep_pkg::t_in_word              i_in_word,
    input  logic                              i_cfg_we,
    input  logic [smstep_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smstep_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  smstep_pkg::t_dp_cmd               i_cmd,
    output smstep_pkg::t_dp_status            o_status,
    output smstep_pkg::t_out_word             o_out_word
);
    import smstep_pkg::*;

    localparam int LIM_W = $clog2(ANGLE_LIMIT + 1);
    localparam int AW    = (LIM_W > ANGLE_FW) ? LIM_W : ANGLE_FW;
    localparam int SW    = AW + 2;
    localparam int MW    = AW + US_W;
    localparam int QW    = MW;
    localparam int PW    = MW + 2;
    localparam int P2W   = DIV_W + DUTY_BITS;
    localparam int CNT_W = $clog2(QW + 1);
    // reciprocal scaling by the frame length: pulse*top < FRAME_US << DUTY_BITS
    localparam int FR_W  = $clog2(FRAME_US);
    localparam int NX    = FR_W + DUTY_BITS;
    localparam int RS    = NX + FR_W;
    localparam int RW    = NX + 2;
    localparam int PRW   = NX + RW;
    localparam logic [RW-1:0] RCP_V =
        RW'(((64'd1 << RS) + 64'(FRAME_US) - 64'd1) / 64'(FRAME_US));
    localparam logic [DUTY_BITS-1:0] TOP_V    = DUTY_BITS'((1 << DUTY_BITS) - 1);
    localparam logic signed [PW-1:0] PERIOD_S = PW'(FRAME_US);
    localparam logic [STEP_W-1:0]    STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};
    localparam logic [STEP_W-1:0]    STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};

    function automatic logic [AW-1:0] sat_angle(input logic signed [SW-1:0] a);
        logic [AW-1:0] res;
        if (a < 0) begin
            res = '0;
        end else if (a > $signed(SW'(ANGLE_LIMIT))) begin
            res = AW'(ANGLE_LIMIT);
        end else begin
            res = a[AW-1:0];
        end
        return res;
    endfunction

    // configuration registers
    logic [MODE_W-1:0]   r_mode;
    logic [ANGLE_FW-1:0] r_start;
    logic [ANGLE_FW-1:0] r_stop;
    logic [ANGLE_FW-1:0] r_max;
    logic [US_W-1:0]     r_pmin;
    logic [US_W-1:0]     r_pmax;

    // motion state
    logic [AW-1:0]            r_angle;
    logic signed [STEP_W-1:0] r_live_step;
    logic                     r_motion;
    logic [AW-1:0]            n_angle;
    logic signed [STEP_W-1:0] n_live_step;
    logic                     n_motion;

    // duty pipeline
    logic [MW-1:0]           r_prod_mag;
    logic                    r_prod_neg;
    logic signed [PW-1:0]    r_pulse;
    logic signed [PW-1:0]    n_pulse;
    logic [P2W-1:0]          r_p2;
    logic [DUTY_BITS-1:0]    r_duty_q;
    t_out_word               r_out;

    logic signed [SW-1:0]    sum_s;
    logic signed [SW-1:0]    start_s;
    logic signed [SW-1:0]    stop_s;
    logic signed [STEP_W-1:0] step_neg;
    logic                    step_zero;
    logic                    step_lt0;
    logic signed [US_W:0]    pdiff;
    logic [US_W-1:0]         pdiff_mag;
    logic signed [PW-1:0]    q_s;
    logic                    pulse_neg;
    logic                    pulse_big;
    logic [PRW-1:0]          scaled;
    logic [DUTY_BITS-1:0]    duty_full;

    logic                    div_start;
    logic [QW-1:0]           div_dividend;
    logic [DIV_W-1:0]        div_rem_init;
    logic [DIV_W-1:0]        div_divisor;
    logic [CNT_W-1:0]        div_steps;
    logic                    div_busy;
    logic [QW-1:0]           div_quo;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_start <= RST_START_ANGLE;
            r_stop  <= RST_STOP_ANGLE;
            r_max   <= RST_MAX_ANGLE;
            r_pmin  <= RST_PULSE_MIN;
            r_pmax  <= RST_PULSE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:        r_mode  <= i_cfg_data[MODE_W-1:0];
                REG_START_ANGLE: r_start <= i_cfg_data[ANGLE_FW-1:0];
                REG_STOP_ANGLE:  r_stop  <= i_cfg_data[ANGLE_FW-1:0];
                REG_MAX_ANGLE:   r_max   <= i_cfg_data[ANGLE_FW-1:0];
                REG_PULSE_MIN:   r_pmin  <= i_cfg_data[US_W-1:0];
                REG_PULSE_MAX:   r_pmax  <= i_cfg_data[US_W-1:0];
                default: ;
            endcase
        end
    end

    // next position arithmetic
    assign sum_s     = $signed(SW'(r_angle)) + SW'(r_live_step);
    assign start_s   = $signed(SW'(r_start));
    assign stop_s    = $signed(SW'(r_stop));
    assign step_zero = (r_live_step == '0);
    assign step_lt0  = r_live_step[STEP_W-1];
    // negation saturates the most negative step
    assign step_neg  = (r_live_step == $signed(STEP_MIN)) ? $signed(STEP_MAX) : -r_live_step;

    // item update
    always_comb begin
        n_angle     = r_angle;
        n_live_step = r_live_step;
        n_motion    = r_motion;
        if (i_cmd.apply) begin
            unique case (i_in_word.cmd)
                CMD_TICK: begin
                    if (r_motion) begin
                        if (step_zero) begin
                            n_motion = 1'b0;
                        end
                        unique case (r_mode)
                            MODE_LOOP: begin
                                if (step_lt0) begin
                                    n_angle = (sum_s < stop_s) ? AW'(r_start) : sat_angle(sum_s);
                                end else if (!step_zero) begin
                                    n_angle = (sum_s > stop_s) ? AW'(r_start) : sat_angle(sum_s);
                                end
                            end
                            MODE_SWEEP: begin
                                if (step_lt0) begin
                                    if (sum_s > start_s) begin
                                        n_angle = sat_angle(sum_s);
                                    end else begin
                                        n_angle     = '0;
                                        n_live_step = step_neg;
                                    end
                                end else begin
                                    if (sum_s < stop_s) begin
                                        n_angle = sat_angle(sum_s);
                                    end else begin
                                        n_angle     = sat_angle($signed(SW'(r_max)));
                                        n_live_step = step_neg;
                                    end
                                end
                            end
                            MODE_ONESHOT: begin
                                if (step_lt0) begin
                                    if (sum_s >= start_s) begin
                                        n_angle = sat_angle(sum_s);
                                    end else begin
                                        n_motion = 1'b0;
                                    end
                                end else begin
                                    if (sum_s <= stop_s) begin
                                        n_angle = sat_angle(sum_s);
                                    end else begin
                                        n_motion = 1'b0;
                                    end
                                end
                            end
                            MODE_OFF: n_motion = 1'b0;
                        endcase
                    end
                end
                CMD_SET_POS: n_angle  = sat_angle($signed(SW'(i_in_word.new_angle)));
                CMD_ENABLE:  n_motion = 1'b1;
                CMD_DISABLE: n_motion = 1'b0;
            endcase
        end
    end

    // motion state registers, a step write reloads the running step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle     <= '0;
            r_live_step <= $signed(RST_STEP_SIZE);
            r_motion    <= 1'b0;
        end else begin
            r_angle  <= n_angle;
            r_motion <= n_motion;
            if (i_cfg_we && i_cfg_idx == REG_STEP_SIZE) begin
                r_live_step <= $signed(i_cfg_data[STEP_W-1:0]);
            end else begin
                r_live_step <= n_live_step;
            end
        end
    end

    // pulse span times angle, kept as magnitude and sign
    assign pdiff     = $signed({1'b0, r_pmax}) - $signed({1'b0, r_pmin});
    assign pdiff_mag = pdiff[US_W] ? US_W'(-pdiff) : pdiff[US_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_prod_mag <= MW'(r_angle) * MW'(pdiff_mag);
            r_prod_neg <= pdiff[US_W];
        end
    end

    // pulse width: signed quotient plus the minimum
    assign q_s = $signed(PW'(div_quo));

    always_comb begin
        if (r_max == '0) begin
            n_pulse = $signed(PW'(r_pmin));
        end else begin
            n_pulse = (r_prod_neg ? -q_s : q_s) + $signed(PW'(r_pmin));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pulse) begin
            r_pulse <= n_pulse;
        end
    end

    // out-of-range pulses skip the period scaling
    assign pulse_neg = r_pulse[PW-1];
    assign pulse_big = !pulse_neg && (r_pulse >= PERIOD_S);

    // pulse times full-scale duty
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_p2 <= P2W'(r_pulse[DIV_W-1:0]) * P2W'(TOP_V);
        end
    end

    // divide by the frame length as a multiply by its rounded-up reciprocal
    assign scaled = PRW'(r_p2[NX-1:0]) * PRW'(RCP_V);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_duty_q <= scaled[RS +: DUTY_BITS];
        end
    end

    // serial divide of the span product by the max angle
    assign div_start    = i_cmd.div1_go;
    assign div_dividend = r_prod_mag;
    assign div_rem_init = '0;
    assign div_divisor  = DIV_W'(r_max);
    assign div_steps    = CNT_W'(QW);

    smstep_div #(
        .QW (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_rem_init (div_rem_init),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // result word
    always_comb begin
        if (pulse_neg) begin
            duty_full = '0;
        end else if (pulse_big) begin
            duty_full = TOP_V;
        end else begin
            duty_full = r_duty_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.angle   <= r_angle[ANGLE_FW-1:0];
            r_out.duty    <= DUTY_FW'(duty_full);
            r_out.running <= r_motion;
        end
    end

    assign o_out_word          = r_out;
    assign o_status.max_zero   = (r_max == '0);
    assign o_status.div_busy   = div_busy;
    assign o_status.skip_scale = pulse_neg | pulse_big;

endmodule

FILE: sv/smstep_ctrl.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module smstep_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  smstep_pkg::t_dp_status i_status,
    output smstep_pkg::t_dp_cmd    o_cmd
);
    import smstep_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL1   = 4'd1;
    localparam logic [3:0] S_D1GO   = 4'd2;
    localparam logic [3:0] S_D1WAIT = 4'd3;
    localparam logic [3:0] S_PULSE  = 4'd4;
    localparam logic [3:0] S_MUL2   = 4'd5;
    localparam logic [3:0] S_SCALE  = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // sequencing of one word
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = i_status.max_zero ? S_PULSE : S_D1GO;
            end
            S_D1GO: begin
                o_cmd.div1_go = 1'b1;
                n_state       = S_D1WAIT;
            end
            S_D1WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_PULSE;
                end
            end
            S_PULSE: begin
                o_cmd.pulse = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = i_status.skip_scale ? S_OUT : S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, o_cmd.apply, r_state == S_MUL1, "accepted word did not start")
    `ASSERT_CLK(a_div_idle_go, i_clk, i_rst_n, o_cmd.div1_go |-> !i_status.div_busy, "divide issued while busy")
    `ASSERT_CLK(a_out_from_last, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_OUT), "result raised outside last stage")

endmodule

FILE: sv/servo_motion_stepper.sv
`timescale 1ns / 1ps

// sequence: accept, span multiply, serial divide (MW = angle bits + 15 quotient bits),
// pulse, duty multiply, period scaling, result stored; the divide is skipped when the
// max angle is zero and the scaling when the duty saturates
// throughput: one word at a time, next word accepted the cycle after the result is stored;
// a full output slot stalls a word before its result is stored; the longest step is the one-bit-per-cycle divide
// reset: synchronous active-low, registers go to their listed defaults, angle 0, stopped

module servo_motion_stepper #(
    parameter int FRAME_US    = smstep_pkg::FRAME_US_DEF,
    parameter int DUTY_BITS   = smstep_pkg::DUTY_BITS_DEF,
    parameter int ANGLE_LIMIT = smstep_pkg::ANGLE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  smstep_pkg::t_in_word              i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output smstep_pkg::t_out_word             o_out_word,
    input  logic                              i_cfg_we,
    input  logic [smstep_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smstep_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import smstep_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    smstep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // motion state, registers and duty arithmetic
    smstep_dp #(
        .FRAME_US    (FRAME_US),
        .DUTY_BITS   (DUTY_BITS),
        .ANGLE_LIMIT (ANGLE_LIMIT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_word (o_out_word)
    );

endmodule
